FILE: rtl/rtp_hdr_pkg.sv
// ----------------------------------------------------------------------------
// rtp_hdr_pkg
// Shared constants, status codes and word types of the RTP header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_hdr_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 2048;
  // position counter holds MAX_PACKET_BYTES + 1 (oversize mark)
  localparam int unsigned POS_W     = $clog2(MAX_PACKET_BYTES + 2);
  localparam int unsigned CAP_W     = 18;
  localparam int unsigned CMP_W     = 20;
  localparam int unsigned HDR_LEN_W = 11;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned ADDR_W    = 3;

  localparam logic [15:0]          ONE_BYTE_PROFILE = 16'hBEDE;
  localparam logic [CMP_W-1:0]     FIXED_HEADER     = CMP_W'(12);
  localparam logic [CMP_W-1:0]     EXT_HDR_BYTES    = CMP_W'(4);
  localparam logic [3:0]           RESERVED_ID      = 4'd15;
  localparam logic [3:0]           PAD_ID           = 4'd0;
  localparam logic [1:0]           RTP_VERSION      = 2'd2;
  localparam logic [CNT_W-1:0]     MAX_EXT_RESET    = CNT_W'(14);
  localparam logic [HDR_LEN_W-1:0] HDR_LEN_MAX      = {HDR_LEN_W{1'b1}};

  // register index, taken from paddr[2]
  localparam logic IDX_MAX_EXT = 1'b0;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_SHORT         = 4'd1,
    ST_VERSION       = 4'd2,
    ST_CSRC_SHORT    = 4'd3,
    ST_ZERO_PAD      = 4'd4,
    ST_EXT_HDR_SHORT = 4'd5,
    ST_EXT_LONG      = 4'd6,
    ST_TOO_MANY      = 4'd7,
    ST_PAD_LONG      = 4'd8,
    ST_OVERSIZE      = 4'd9
  } status_e;

  // header state as it stands after the last byte of a packet
  typedef struct packed {
    logic [POS_W-1:0] n;
    logic [7:0]       first;
    logic [7:0]       second;
    logic [7:0]       last_data;
    logic [15:0]      seq;
    logic [31:0]      stamp;
    logic [31:0]      source;
    logic [15:0]      profile;
    logic [CAP_W-1:0] cap;
    logic             too_many;
  } snap_t;

  typedef struct packed {
    status_e              status;
    logic                 marker;
    logic [6:0]           payload_kind;
    logic [15:0]          sequence_number;
    logic [31:0]          time_stamp;
    logic [31:0]          source_id;
    logic [HDR_LEN_W-1:0] header_length;
    logic [7:0]           padding_length;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/rtp_hdr_track.sv
// ----------------------------------------------------------------------------
// rtp_hdr_track
// Per-byte header capture and one-byte extension walk. Gives the updated
// packet state as a snapshot and clears itself after a last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_hdr_track (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_i,
  input  wire logic [7:0]                         data_byte_i,
  input  wire logic                               last_byte_i,
  input  wire logic [rtp_hdr_pkg::CNT_W-1:0]      max_ext_i,
  output rtp_hdr_pkg::snap_t                      snap_o
);

  localparam int unsigned POS_W = rtp_hdr_pkg::POS_W;
  localparam int unsigned CAP_W = rtp_hdr_pkg::CAP_W;
  localparam int unsigned CMP_W = rtp_hdr_pkg::CMP_W;
  localparam int unsigned CNT_W = rtp_hdr_pkg::CNT_W;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       first_q, first_d;
  logic [7:0]       second_q, second_d;
  logic [15:0]      seq_q, seq_d;
  logic [31:0]      stamp_q, stamp_d;
  logic [31:0]      source_q, source_d;
  logic [15:0]      profile_q, profile_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [POS_W-1:0] next_q, next_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             stopped_q, stopped_d;
  logic             too_many_q, too_many_d;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] hdr_x;
  logic [CMP_W-1:0] rel_x;
  logic             walk_en;

  assign pos_x = CMP_W'(pos_q);
  assign hdr_x = rtp_hdr_pkg::FIXED_HEADER + CMP_W'({first_q[3:0], 2'b00});
  assign rel_x = pos_x - (hdr_x + rtp_hdr_pkg::EXT_HDR_BYTES);

  // a walk step only lands on the byte where the next element starts
  assign walk_en = !stopped_q && !too_many_q && (rel_x == CMP_W'(next_q)) &&
                   ((CMP_W'(next_q) + CMP_W'(1)) < CMP_W'(cap_q));

  always_comb begin
    pos_d      = pos_q;
    first_d    = first_q;
    second_d   = second_q;
    seq_d      = seq_q;
    stamp_d    = stamp_q;
    source_d   = source_q;
    profile_d  = profile_q;
    cap_d      = cap_q;
    next_d     = next_q;
    count_d    = count_q;
    stopped_d  = stopped_q;
    too_many_d = too_many_q;

    if (step_i) begin
      if (pos_q < POS_W'(rtp_hdr_pkg::MAX_PACKET_BYTES)) begin
        pos_d = pos_q + POS_W'(1);
        priority if (pos_x == CMP_W'(0)) begin
          first_d = data_byte_i;
        end else if (pos_x == CMP_W'(1)) begin
          second_d = data_byte_i;
        end else if (pos_x < CMP_W'(4)) begin
          seq_d = {seq_q[7:0], data_byte_i};
        end else if (pos_x < CMP_W'(8)) begin
          stamp_d = {stamp_q[23:0], data_byte_i};
        end else if (pos_x < CMP_W'(12)) begin
          source_d = {source_q[23:0], data_byte_i};
        end else if (first_q[4]) begin
          priority if (pos_x == hdr_x) begin
            profile_d = {data_byte_i, 8'h00};
          end else if (pos_x == hdr_x + CMP_W'(1)) begin
            profile_d = profile_q | {8'h00, data_byte_i};
          end else if (pos_x == hdr_x + CMP_W'(2)) begin
            cap_d = {data_byte_i, 10'b0};
          end else if (pos_x == hdr_x + CMP_W'(3)) begin
            cap_d = cap_q | {8'h00, data_byte_i, 2'b00};
          end else if (profile_q == rtp_hdr_pkg::ONE_BYTE_PROFILE && walk_en) begin
            priority if (data_byte_i[7:4] == rtp_hdr_pkg::RESERVED_ID) begin
              stopped_d = 1'b1;
            end else if (data_byte_i[7:4] == rtp_hdr_pkg::PAD_ID) begin
              next_d = next_q + POS_W'(1);
            end else if (count_q >= max_ext_i) begin
              too_many_d = 1'b1;
            end else begin
              count_d = count_q + CNT_W'(1);
              next_d  = next_q + POS_W'(2) + POS_W'(data_byte_i[3:0]);
            end
          end else begin
            next_d = next_q;
          end
        end else begin
          first_d = first_q;
        end
      end else begin
        pos_d = POS_W'(rtp_hdr_pkg::MAX_PACKET_BYTES + 1);
      end
    end

    snap_o.n         = pos_d;
    snap_o.first     = first_d;
    snap_o.second    = second_d;
    snap_o.last_data = data_byte_i;
    snap_o.seq       = seq_d;
    snap_o.stamp     = stamp_d;
    snap_o.source    = source_d;
    snap_o.profile   = profile_d;
    snap_o.cap       = cap_d;
    snap_o.too_many  = too_many_d;

    if (step_i && last_byte_i) begin
      pos_d      = '0;
      first_d    = '0;
      second_d   = '0;
      seq_d      = '0;
      stamp_d    = '0;
      source_d   = '0;
      profile_d  = '0;
      cap_d      = '0;
      next_d     = '0;
      count_d    = '0;
      stopped_d  = 1'b0;
      too_many_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      first_q    <= '0;
      second_q   <= '0;
      seq_q      <= '0;
      stamp_q    <= '0;
      source_q   <= '0;
      profile_q  <= '0;
      cap_q      <= '0;
      next_q     <= '0;
      count_q    <= '0;
      stopped_q  <= 1'b0;
      too_many_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      first_q    <= first_d;
      second_q   <= second_d;
      seq_q      <= seq_d;
      stamp_q    <= stamp_d;
      source_q   <= source_d;
      profile_q  <= profile_d;
      cap_q      <= cap_d;
      next_q     <= next_d;
      count_q    <= count_d;
      stopped_q  <= stopped_d;
      too_many_q <= too_many_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rtp_hdr_check.sv
// ----------------------------------------------------------------------------
// rtp_hdr_check
// End-of-packet checks: status in priority order, header and padding length.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_hdr_check (
  input  rtp_hdr_pkg::snap_t   snap_i,
  output rtp_hdr_pkg::result_t result_o
);

  localparam int unsigned CMP_W     = rtp_hdr_pkg::CMP_W;
  localparam int unsigned HDR_LEN_W = rtp_hdr_pkg::HDR_LEN_W;

  logic [CMP_W-1:0]     n_x;
  logic [CMP_W-1:0]     h0_x;
  logic [CMP_W-1:0]     off_x;
  logic [CMP_W-1:0]     hl_x;
  logic [7:0]           padl;
  logic [HDR_LEN_W-1:0] hl;
  rtp_hdr_pkg::status_e st;

  assign n_x   = CMP_W'(snap_i.n);
  assign h0_x  = rtp_hdr_pkg::FIXED_HEADER + CMP_W'({snap_i.first[3:0], 2'b00});
  assign off_x = h0_x + rtp_hdr_pkg::EXT_HDR_BYTES;

  always_comb begin
    st   = rtp_hdr_pkg::ST_OK;
    hl_x = '0;
    padl = '0;
    priority if (n_x > CMP_W'(rtp_hdr_pkg::MAX_PACKET_BYTES)) begin
      st = rtp_hdr_pkg::ST_OVERSIZE;
    end else if (n_x < rtp_hdr_pkg::FIXED_HEADER) begin
      st = rtp_hdr_pkg::ST_SHORT;
    end else if (snap_i.first[7:6] != rtp_hdr_pkg::RTP_VERSION) begin
      st = rtp_hdr_pkg::ST_VERSION;
    end else if (n_x < h0_x) begin
      st = rtp_hdr_pkg::ST_CSRC_SHORT;
    end else begin
      hl_x = h0_x;
      if (snap_i.first[5]) begin
        padl = snap_i.last_data;
        if (snap_i.last_data == 8'h00) begin
          st = rtp_hdr_pkg::ST_ZERO_PAD;
        end
      end
      if (st == rtp_hdr_pkg::ST_OK && snap_i.first[4]) begin
        priority if (off_x > n_x) begin
          st = rtp_hdr_pkg::ST_EXT_HDR_SHORT;
        end else if (off_x + CMP_W'(snap_i.cap) > n_x) begin
          st = rtp_hdr_pkg::ST_EXT_LONG;
        end else if (snap_i.profile == rtp_hdr_pkg::ONE_BYTE_PROFILE && snap_i.too_many) begin
          st = rtp_hdr_pkg::ST_TOO_MANY;
        end else begin
          hl_x = off_x + CMP_W'(snap_i.cap);
        end
      end
      if (st == rtp_hdr_pkg::ST_OK && (hl_x + CMP_W'(padl)) > n_x) begin
        st = rtp_hdr_pkg::ST_PAD_LONG;
      end
    end
    hl = (hl_x > CMP_W'(rtp_hdr_pkg::HDR_LEN_MAX)) ? rtp_hdr_pkg::HDR_LEN_MAX
                                                   : hl_x[HDR_LEN_W-1:0];
  end

  always_comb begin
    result_o.status          = st;
    result_o.marker          = snap_i.second[7];
    result_o.payload_kind    = snap_i.second[6:0];
    result_o.sequence_number = snap_i.seq;
    result_o.time_stamp      = snap_i.stamp;
    result_o.source_id       = snap_i.source;
    result_o.header_length   = hl;
    result_o.padding_length  = padl;
  end

endmodule

`default_nettype wire

FILE: rtl/rtp_header_parser_core.sv
// Path: a last byte passes the input register, the header state update and the
//   snapshot register, then the check and result register; out_stall_i can hold it.
// Throughput: one byte per cycle; only a last byte stalls, when the snapshot
//   stage is full and the result register waits on out_stall_i.
// Reset: rst_ni clears all packet state and the pipeline valids at once;
//   max_extension_elements resets to 14.
// ----------------------------------------------------------------------------
// rtp_header_parser_core
// Streaming RTP header parser with one-byte extension walk, APB config port.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_header_parser_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // byte input
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire logic [7:0]                           data_byte_i,
  input  wire logic                                 last_byte_i,
  // result output
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic [3:0]                           status_o,
  output      logic                                 marker_o,
  output      logic [6:0]                           payload_kind_o,
  output      logic [15:0]                          sequence_number_o,
  output      logic [31:0]                          time_stamp_o,
  output      logic [31:0]                          source_id_o,
  output      logic [rtp_hdr_pkg::HDR_LEN_W-1:0]    header_length_o,
  output      logic [7:0]                           padding_length_o,
  // config
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [rtp_hdr_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [31:0]                          pwdata,
  output      logic [31:0]                          prdata,
  output      logic                                 pready
);

  localparam int unsigned CNT_W  = rtp_hdr_pkg::CNT_W;
  localparam int unsigned ADDR_W = rtp_hdr_pkg::ADDR_W;

  // config register
  logic [CNT_W-1:0] max_ext_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1] == rtp_hdr_pkg::IDX_MAX_EXT);
  assign prdata = (paddr[ADDR_W-1] == rtp_hdr_pkg::IDX_MAX_EXT) ?
                  {{(32-CNT_W){1'b0}}, max_ext_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ext_q <= rtp_hdr_pkg::MAX_EXT_RESET;
    end else if (cfg_wr) begin
      max_ext_q <= pwdata[CNT_W-1:0];
    end
  end

  // pipeline control
  logic s1_valid_q, s1_valid_d;
  logic s1_last_q;
  logic [7:0] s1_data_q;
  logic s2_valid_q, s2_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free, s2_free, s1_consume, in_accept, s2_load, s2_move;

  rtp_hdr_pkg::snap_t   snap_c;
  rtp_hdr_pkg::snap_t   s2_snap_q;
  rtp_hdr_pkg::result_t res_c;
  rtp_hdr_pkg::result_t out_res_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_free    = !s2_valid_q || out_free;
  // non-last bytes only update state, a last byte needs the snapshot slot
  assign s1_consume = s1_valid_q && (!s1_last_q || s2_free);
  assign in_stall_o = s1_valid_q && !s1_consume;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s2_load    = s1_consume && s1_last_q;
  assign s2_move    = s2_valid_q && out_free;

  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_consume);
  assign s2_valid_d  = s2_load || (s2_valid_q && !out_free);
  assign out_valid_d = s2_move || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (s2_load) begin
      s2_snap_q <= snap_c;
    end
    if (s2_move) begin
      out_res_q <= res_c;
    end
  end

  rtp_hdr_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_consume),
    .data_byte_i (s1_data_q),
    .last_byte_i (s1_last_q),
    .max_ext_i   (max_ext_q),
    .snap_o      (snap_c)
  );

  rtp_hdr_check u_check (
    .snap_i   (s2_snap_q),
    .result_o (res_c)
  );

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_res_q.status;
  assign marker_o          = out_res_q.marker;
  assign payload_kind_o    = out_res_q.payload_kind;
  assign sequence_number_o = out_res_q.sequence_number;
  assign time_stamp_o      = out_res_q.time_stamp;
  assign source_id_o       = out_res_q.source_id;
  assign header_length_o   = out_res_q.header_length;
  assign padding_length_o  = out_res_q.padding_length;

`ifndef ASSERT_OFF
  // a waiting snapshot is never dropped while the output is blocked
  a_snap_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_free |=> s2_valid_q)
    else $error("snapshot lost while output stalled");

  // input only stalls behind a last byte that has nowhere to go
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && s2_valid_q)
    else $error("input stalled without a blocked last byte");

  // early failures carry no lengths
  a_fail_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rtp_hdr_pkg::ST_OVERSIZE ||
                    status_o == rtp_hdr_pkg::ST_SHORT ||
                    status_o == rtp_hdr_pkg::ST_VERSION) |->
      header_length_o == '0 && padding_length_o == '0)
    else $error("lengths set on early failure");
`endif

endmodule

`default_nettype wire

FILE: dv/rtp_header_parser_core_test.sv
// ----------------------------------------------------------------------------
// rtp_header_parser_core_test
// Feeds RTP packets a byte at a time and predicts the header result of each
// one. Covers every status code, the one-byte extension walk with several
// element limits, and random traffic with idle and stall on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rtp_header_parser_core_test;
  import rtp_hdr_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT = 40;
  localparam logic [ADDR_W-1:0] REG_MAX_EXT_ADDR = ADDR_W'(4 * IDX_MAX_EXT);

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i = '0;
  logic                 last_byte_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [3:0]           status_o;
  logic                 marker_o;
  logic [6:0]           payload_kind_o;
  logic [15:0]          sequence_number_o;
  logic [31:0]          time_stamp_o;
  logic [31:0]          source_id_o;
  logic [HDR_LEN_W-1:0] header_length_o;
  logic [7:0]           padding_length_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  rtp_header_parser_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .marker_o          (marker_o),
    .payload_kind_o    (payload_kind_o),
    .sequence_number_o (sequence_number_o),
    .time_stamp_o      (time_stamp_o),
    .source_id_o       (source_id_o),
    .header_length_o   (header_length_o),
    .padding_length_o  (padding_length_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // header parse state of the packet in flight
  logic [11:0]      byte_cnt = '0;
  logic [7:0]       hdr_first = '0;
  logic [7:0]       hdr_second = '0;
  logic [15:0]      seq_acc = '0;
  logic [31:0]      stamp_acc = '0;
  logic [31:0]      ssrc_acc = '0;
  logic [15:0]      ext_prof = '0;
  logic [CAP_W-1:0] ext_cap = '0;
  logic [CAP_W-1:0] walk_pos = '0;
  logic [3:0]       walk_elems = '0;
  logic             walk_done = 1'b0;
  logic             walk_overflow = 1'b0;
  logic [3:0]       max_elems = MAX_EXT_RESET;

  result_t     expected_headers[$];
  logic [7:0]  pkt[$];
  int          n_errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          pause_cycles = 0;
  int          pause_req = 0;
  int          pause_seen = 0;
  int          pause_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= PRINT_LIMIT) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned p, h0, off, hl, padl, n, rel;
    status_e st;
    result_t r;
    p = byte_cnt;
    h0 = 12 + 4 * hdr_first[3:0];
    if (p < MAX_PACKET_BYTES) begin
      if (p == 0) hdr_first = b;
      else if (p == 1) hdr_second = b;
      else if (p < 4) seq_acc = {seq_acc[7:0], b};
      else if (p < 8) stamp_acc = {stamp_acc[23:0], b};
      else if (p < 12) ssrc_acc = {ssrc_acc[23:0], b};
      else if (hdr_first[4]) begin
        if (p == h0) ext_prof = {b, 8'h00};
        else if (p == h0 + 1) ext_prof = ext_prof | {8'h00, b};
        else if (p == h0 + 2) ext_cap = {b, 10'b0};
        else if (p == h0 + 3) ext_cap = ext_cap | {8'h00, b, 2'b0};
        else if (p >= h0 + 4 && ext_prof == ONE_BYTE_PROFILE) begin
          rel = p - (h0 + 4);
          if (!walk_done && !walk_overflow && rel == walk_pos && walk_pos + 1 < ext_cap) begin
            if (b[7:4] == RESERVED_ID) walk_done = 1'b1;
            else if (b[7:4] == PAD_ID) walk_pos = walk_pos + 1;
            else if (walk_elems >= max_elems) walk_overflow = 1'b1;
            else begin
              walk_elems = walk_elems + 1;
              walk_pos = walk_pos + 2 + b[3:0];
            end
          end
        end
      end
      byte_cnt = 12'(p + 1);
    end else begin
      byte_cnt = 12'(MAX_PACKET_BYTES + 1);
    end
    if (!last) return;

    n = byte_cnt;
    h0 = 12 + 4 * hdr_first[3:0];
    hl = 0;
    padl = 0;
    st = ST_OK;
    if (n > MAX_PACKET_BYTES) st = ST_OVERSIZE;
    else if (n < 12) st = ST_SHORT;
    else if (hdr_first[7:6] != RTP_VERSION) st = ST_VERSION;
    else if (n < h0) st = ST_CSRC_SHORT;
    else begin
      hl = h0;
      if (hdr_first[5]) begin
        padl = b;
        if (b == 8'h00) st = ST_ZERO_PAD;
      end
      if (st == ST_OK && hdr_first[4]) begin
        off = h0 + 4;
        if (off > n) st = ST_EXT_HDR_SHORT;
        else if (off + ext_cap > n) st = ST_EXT_LONG;
        else if (ext_prof == ONE_BYTE_PROFILE && walk_overflow) st = ST_TOO_MANY;
        else hl = off + ext_cap;
      end
      if (st == ST_OK && hl + padl > n) st = ST_PAD_LONG;
    end
    r.status = st;
    r.marker = hdr_second[7];
    r.payload_kind = hdr_second[6:0];
    r.sequence_number = seq_acc;
    r.time_stamp = stamp_acc;
    r.source_id = ssrc_acc;
    r.header_length = (hl > HDR_LEN_MAX) ? HDR_LEN_MAX : HDR_LEN_W'(hl);
    r.padding_length = padl[7:0];
    expected_headers.push_back(r);

    byte_cnt = '0;
    hdr_first = '0;
    hdr_second = '0;
    seq_acc = '0;
    stamp_acc = '0;
    ssrc_acc = '0;
    ext_prof = '0;
    ext_cap = '0;
    walk_pos = '0;
    walk_elems = '0;
    walk_done = 1'b0;
    walk_overflow = 1'b0;
  endtask

  // result check first, then the byte that enters at the same edge
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_headers.size() == 0) begin
          report_mismatch("unexpected result word", '0, '0);
        end else begin
          want = expected_headers.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (marker_o !== want.marker)
            report_mismatch("marker", marker_o, want.marker);
          if (payload_kind_o !== want.payload_kind)
            report_mismatch("payload_kind", payload_kind_o, want.payload_kind);
          if (sequence_number_o !== want.sequence_number)
            report_mismatch("sequence_number", sequence_number_o, want.sequence_number);
          if (time_stamp_o !== want.time_stamp)
            report_mismatch("time_stamp", time_stamp_o, want.time_stamp);
          if (source_id_o !== want.source_id)
            report_mismatch("source_id", source_id_o, want.source_id);
          if (header_length_o !== want.header_length)
            report_mismatch("header_length", header_length_o, want.header_length);
          if (padding_length_o !== want.padding_length)
            report_mismatch("padding_length", padding_length_o, want.padding_length);
        end
      end
      if (in_valid_i && !in_stall_o) parse_byte(data_byte_i, last_byte_i);
    end
  end

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk_i) begin : out_stall_gen
    if (pause_req != pause_seen) begin
      pause_seen = pause_req;
      pause_left = pause_cycles;
    end
    if (pause_left != 0) pause_left--;
    out_stall_i <= (pause_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk_i);
    // a packet tail with no result may still sit in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= REG_MAX_EXT_ADDR;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic set_max_elements(input logic [3:0] limit);
    logic [31:0] readback;
    wait_until_drained();
    apb_access(1'b1, 32'(limit), readback);
    max_elems = limit;
    apb_access(1'b0, '0, readback);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== 32'(limit))
      report_mismatch("max_extension_elements readback", readback, 32'(limit));
  endtask

  // fixed header, CSRCs, optional extension, payload, optional padding
  task automatic build_packet(input logic [7:0] first, input int words,
                              input logic [15:0] prof, input int n_elems,
                              input int max_len, input bit stop,
                              input int payload_len, input logic [7:0] pad_len);
    int body_len, k, len, elems, filler, j;
    pkt.delete();
    pkt.push_back(first);
    repeat (11 + 4 * first[3:0]) pkt.push_back(8'($urandom));
    if (first[4]) begin
      pkt.push_back(prof[15:8]);
      pkt.push_back(prof[7:0]);
      pkt.push_back(8'(words >> 8));
      pkt.push_back(8'(words));
      body_len = 4 * words;
      k = 0;
      elems = 0;
      filler = 0;
      while (k < body_len) begin
        if (prof != ONE_BYTE_PROFILE) begin
          pkt.push_back(8'($urandom));
          k++;
        end else if (elems < n_elems) begin
          if ($urandom_range(9) == 0) begin
            pkt.push_back({PAD_ID, 4'($urandom)});
            k++;
          end else begin
            len = $urandom_range(max_len);
            pkt.push_back({4'($urandom_range(1, 14)), 4'(len)});
            k++;
            // an element's length may run past the body end; its data stops there
            for (j = 0; j <= len && k < body_len; j++) begin
              pkt.push_back(8'($urandom));
              k++;
            end
            elems++;
          end
        end else begin
          if (!stop) pkt.push_back(8'h00);
          else if (filler == 0) pkt.push_back({RESERVED_ID, 4'($urandom)});
          else pkt.push_back(8'($urandom));
          filler++;
          k++;
        end
      end
    end
    repeat (payload_len) pkt.push_back(8'($urandom));
    if (first[5]) begin
      if (pad_len != 0) repeat (pad_len - 1) pkt.push_back(8'($urandom));
      pkt.push_back(pad_len);
    end
  endtask

  task automatic test_reset_value();
    logic [31:0] readback;
    apb_access(1'b0, '0, readback);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== 32'(MAX_EXT_RESET))
      report_mismatch("max_extension_elements after reset", readback, 32'(MAX_EXT_RESET));
  endtask

  task automatic test_status_codes();
    // single byte and one byte short of a fixed header
    pkt.delete();
    pkt.push_back(8'hFF);
    send_packet();
    build_packet(8'h80, 0, '0, 0, 0, 0, 4, 8'd0);
    pkt = pkt[0:10];
    send_packet();
    // version 0 and version 3, all bits low and all bits high
    pkt.delete();
    repeat (12) pkt.push_back(8'h00);
    send_packet();
    pkt.delete();
    repeat (12) pkt.push_back(8'hFF);
    send_packet();
    // bare header, then full CSRC list short and complete
    build_packet(8'h80, 0, '0, 0, 0, 0, 0, 8'd0);
    send_packet();
    build_packet(8'h8F, 0, '0, 0, 0, 0, 0, 8'd0);
    pkt = pkt[0:39];
    send_packet();
    build_packet(8'h8F, 0, '0, 0, 0, 0, 4, 8'd0);
    send_packet();
    // padding: zero count, count past the packet, largest count
    build_packet(8'hA0, 0, '0, 0, 0, 0, 5, 8'd0);
    send_packet();
    build_packet(8'h80, 0, '0, 0, 0, 0, 3, 8'd0);
    pkt[0] = 8'hA0;
    pkt.push_back(8'hFF);
    send_packet();
    build_packet(8'hA0, 0, '0, 0, 0, 0, 0, 8'd255);
    send_packet();
    // extension header cut, body cut, largest length word
    build_packet(8'h90, 0, ONE_BYTE_PROFILE, 0, 0, 0, 0, 8'd0);
    pkt = pkt[0:13];
    send_packet();
    build_packet(8'h90, 3, ONE_BYTE_PROFILE, 2, 1, 0, 0, 8'd0);
    pkt = pkt[0:23];
    send_packet();
    build_packet(8'h90, 0, ONE_BYTE_PROFILE, 0, 0, 0, 6, 8'd0);
    pkt[14] = 8'hFF;
    pkt[15] = 8'hFF;
    send_packet();
    // one element more than the reset limit
    build_packet(8'h90, 12, ONE_BYTE_PROFILE, 15, 0, 0, 2, 8'd0);
    send_packet();
    // walk with padding ids and a stop id, another profile, element past the body
    build_packet(8'h90, 6, ONE_BYTE_PROFILE, 3, 3, 1, 8, 8'd0);
    send_packet();
    build_packet(8'h90, 4, 16'h1000, 0, 0, 0, 3, 8'd0);
    send_packet();
    build_packet(8'h90, 1, ONE_BYTE_PROFILE, 2, 15, 0, 4, 8'd0);
    send_packet();
    build_packet(8'hB2, 5, ONE_BYTE_PROFILE, 4, 2, 0, 10, 8'd7);
    send_packet();
    // largest packet with header length past 2047, then an oversize one
    build_packet(8'h90, 508, ONE_BYTE_PROFILE, 14, 15, 0, 0, 8'd0);
    send_packet();
    build_packet(8'h90, 2, ONE_BYTE_PROFILE, 2, 1, 0, 2032, 8'd0);
    send_packet();
  endtask

  task automatic test_extension_limits();
    logic [3:0] limits[3];
    limits = '{4'd0, 4'd15, 4'd1};
    foreach (limits[i]) begin
      set_max_elements(limits[i]);
      build_packet(8'h90, 16, ONE_BYTE_PROFILE, limits[i], 1, 0, 4, 8'd0);
      send_packet();
      build_packet(8'h90, 16, ONE_BYTE_PROFILE, limits[i] + 1, 1, 0, 4, 8'd0);
      send_packet();
      build_packet(8'hB0, 8, ONE_BYTE_PROFILE, $urandom_range(0, 16), 3, $urandom_range(1),
                   6, 8'($urandom_range(1, 9)));
      send_packet();
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    int kind, cut;
    logic [7:0] first;
    logic [15:0] prof;
    set_max_elements(4'($urandom_range(0, 15)));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (20) begin
      kind = $urandom_range(99);
      first = {RTP_VERSION, 1'($urandom_range(9) < 3), 1'($urandom_range(1)),
               4'(($urandom_range(9) == 0) ? 15 : $urandom_range(0, 3))};
      prof = ($urandom_range(4) == 0) ? 16'($urandom) : ONE_BYTE_PROFILE;
      build_packet(first, $urandom_range(0, 6), prof, $urandom_range(0, 16),
                   $urandom_range(0, 3), $urandom_range(1), $urandom_range(0, 24),
                   8'($urandom_range(0, 12)));
      if (kind >= 90) begin
        pkt.delete();
        repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
      end else if (kind >= 82) begin
        pkt[0] = 8'($urandom);
      end else if (kind >= 70) begin
        cut = $urandom_range(1, pkt.size());
        pkt = pkt[0:cut-1];
      end
      send_packet();
    end
  endtask

  // receiver holds off while tiny packets keep coming, so the input must stall
  task automatic test_backpressure();
    set_max_elements(4'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pause_cycles = 300;
    pause_req++;
    repeat (24) begin
      pkt.delete();
      repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
      send_packet();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 63;
    test_reset_value();
    test_status_codes();
    test_extension_limits();
    test_random_traffic(38, 63);
    test_random_traffic(63, 38);
    test_random_traffic(0, 0);
    test_backpressure();
    wait_until_drained();
    if (n_errors == 0) begin
      $display("PASS rtp_header_parser_core");
    end else begin
      $display("FAIL rtp_header_parser_core");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("FAIL rtp_header_parser_core");
    $finish;
  end

endmodule

FILE: files.f
rtl/rtp_hdr_pkg.sv
rtl/rtp_hdr_track.sv
rtl/rtp_hdr_check.sv
rtl/rtp_header_parser_core.sv
dv/rtp_header_parser_core_test.sv
